>>> sv/small_language_tokenizer_assert.svh
// assertion macros for the tokenizer top level
`ifndef SMALL_LANGUAGE_TOKENIZER_ASSERT_SVH
`define SMALL_LANGUAGE_TOKENIZER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SLT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SLT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/slt_pkg.sv
// shared types and constants for the tokenizer
package slt_pkg;

  localparam int STORE_DEPTH = 31;
  localparam int IDX_W       = 5;
  localparam int ADDR_W      = IDX_W + 1;

  typedef enum logic [3:0] {
    TT_INT     = 4'd0,
    TT_IF      = 4'd1,
    TT_IDENT   = 4'd2,
    TT_NUMBER  = 4'd3,
    TT_ASSIGN  = 4'd4,
    TT_PLUS    = 4'd5,
    TT_MINUS   = 4'd6,
    TT_EQUAL   = 4'd7,
    TT_LBRACE  = 4'd8,
    TT_RBRACE  = 4'd9,
    TT_LPAREN  = 4'd10,
    TT_RPAREN  = 4'd11,
    TT_SEMI    = 4'd12,
    TT_UNKNOWN = 4'd13,
    TT_EOF     = 4'd14
  } tok_type_t;

  typedef enum logic [1:0] {
    CK_TEXT,
    CK_CHAR,
    CK_EQ2
  } cmd_kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_word_t;

  typedef struct packed {
    tok_type_t        token_type;
    logic [7:0]       text_char;
    logic [IDX_W-1:0] char_index;
    logic             last_of_token;
    logic             last_of_input;
  } out_word_t;

  typedef struct packed {
    cmd_kind_t        kind;
    tok_type_t        ttype;
    logic [7:0]       ch;
    logic [IDX_W-1:0] len;
    logic             bank;
    logic             last_in;
  } cmd_t;

  typedef struct packed {
    logic v0;
    logic v1;
    cmd_t c0;
    cmd_t c1;
  } cmd_pair_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } mem_wr_t;

  typedef struct packed {
    logic en;
    logic bank;
  } rel_t;

  typedef struct packed {
    logic room2;
    logic empty;
  } q_stat_t;

endpackage

>>> sv/slt_text_mem.sv
// two-bank token text memory, one write and one registered read port
module slt_text_mem import slt_pkg::*; (
  input  logic              clk,
  input  mem_wr_t           wr,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [7:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

>>> sv/slt_front.sv
// byte scanner: classifies input bytes, stores word text, issues token commands
module slt_front import slt_pkg::*; #(
  parameter int MAX_TEXT = 31
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_word_t  in_word,
  input  q_stat_t   q_stat,
  input  rel_t      rel,
  output cmd_pair_t cmd,
  output mem_wr_t   wr
);

  localparam int TEXT_CAP = (MAX_TEXT < STORE_DEPTH) ? MAX_TEXT : STORE_DEPTH;

  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_I      = 8'h69;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_F      = 8'h66;

  typedef enum logic [2:0] {
    MD_IDLE,
    MD_WORD,
    MD_DIGITS,
    MD_EQ,
    MD_SLASH,
    MD_COMMENT
  } mode_t;

  typedef enum logic [2:0] {
    KW_NONE,
    KW_I,
    KW_IN,
    KW_INT,
    KW_IF
  } kw_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  mode_t            mode_r, mode_nxt;
  kw_t              kw_r, kw_nxt;
  logic [IDX_W-1:0] len_r, len_nxt;
  logic             bank_r, bank_nxt;
  logic [1:0]       busy_r, busy_nxt;

  logic       accept;
  logic       text_mode;
  logic [7:0] c;
  logic       eoi;

  cmd_t  f_cmd, s_cmd, i_cmd;
  logic  fv, use_f, use_s, do_idle, ext;
  mode_t i_mode;
  logic  i_sv, i_start;
  logic  wbank;
  logic  ext_store;

  assign c         = in_word.data_byte;
  assign eoi       = in_word.end_of_input;
  assign text_mode = (mode_r == MD_WORD) || (mode_r == MD_DIGITS);
  assign in_full   = !q_stat.room2 || busy_r[bank_r] || (busy_r[!bank_r] && text_mode);
  assign accept    = in_push && !in_full;

  // pending token of the current mode
  always_comb begin
    fv            = 1'b0;
    f_cmd.kind    = CK_CHAR;
    f_cmd.ttype   = TT_UNKNOWN;
    f_cmd.ch      = CH_SLASH;
    f_cmd.len     = len_r;
    f_cmd.bank    = bank_r;
    f_cmd.last_in = 1'b0;
    case (mode_r)
      MD_WORD: begin
        fv         = 1'b1;
        f_cmd.kind = CK_TEXT;
        if (kw_r == KW_INT) begin
          f_cmd.ttype = TT_INT;
        end else if (kw_r == KW_IF) begin
          f_cmd.ttype = TT_IF;
        end else begin
          f_cmd.ttype = TT_IDENT;
        end
      end
      MD_DIGITS: begin
        fv          = 1'b1;
        f_cmd.kind  = CK_TEXT;
        f_cmd.ttype = TT_NUMBER;
      end
      MD_EQ: begin
        fv          = 1'b1;
        f_cmd.ttype = TT_ASSIGN;
        f_cmd.ch    = CH_EQ;
      end
      MD_SLASH: begin
        fv = 1'b1;
      end
      default: begin
        fv = 1'b0;
      end
    endcase
  end

  // byte seen with nothing pending
  always_comb begin
    i_mode        = MD_IDLE;
    i_sv          = 1'b0;
    i_start       = 1'b0;
    i_cmd.kind    = CK_CHAR;
    i_cmd.ttype   = TT_UNKNOWN;
    i_cmd.ch      = c;
    i_cmd.len     = '0;
    i_cmd.bank    = bank_r;
    i_cmd.last_in = 1'b1;
    if (is_blank(c)) begin
      i_mode = MD_IDLE;
    end else if (is_letter(c)) begin
      i_mode  = MD_WORD;
      i_start = 1'b1;
    end else if (is_digit(c)) begin
      i_mode  = MD_DIGITS;
      i_start = 1'b1;
    end else begin
      case (c)
        CH_EQ:     i_mode = MD_EQ;
        CH_SLASH:  i_mode = MD_SLASH;
        CH_PLUS: begin
          i_sv        = 1'b1;
          i_cmd.ttype = TT_PLUS;
        end
        CH_MINUS: begin
          i_sv        = 1'b1;
          i_cmd.ttype = TT_MINUS;
        end
        CH_LBRACE: begin
          i_sv        = 1'b1;
          i_cmd.ttype = TT_LBRACE;
        end
        CH_RBRACE: begin
          i_sv        = 1'b1;
          i_cmd.ttype = TT_RBRACE;
        end
        CH_LPAREN: begin
          i_sv        = 1'b1;
          i_cmd.ttype = TT_LPAREN;
        end
        CH_RPAREN: begin
          i_sv        = 1'b1;
          i_cmd.ttype = TT_RPAREN;
        end
        CH_SEMI: begin
          i_sv        = 1'b1;
          i_cmd.ttype = TT_SEMI;
        end
        default: begin
          i_sv = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    len_nxt   = len_r;
    kw_nxt    = kw_r;
    use_f     = 1'b0;
    use_s     = 1'b0;
    do_idle   = 1'b0;
    ext       = 1'b0;
    s_cmd     = i_cmd;
    if (eoi) begin
      use_f         = fv;
      use_s         = 1'b1;
      s_cmd.ttype   = TT_EOF;
      s_cmd.ch      = '0;
      mode_nxt      = MD_IDLE;
      len_nxt       = '0;
    end else begin
      case (mode_r)
        MD_WORD: begin
          if (is_letter(c) || is_digit(c)) begin
            ext = 1'b1;
          end else begin
            use_f   = 1'b1;
            do_idle = 1'b1;
          end
        end
        MD_DIGITS: begin
          if (is_digit(c)) begin
            ext = 1'b1;
          end else begin
            use_f   = 1'b1;
            do_idle = 1'b1;
          end
        end
        MD_EQ: begin
          if (c == CH_EQ) begin
            use_s       = 1'b1;
            s_cmd.kind  = CK_EQ2;
            s_cmd.ttype = TT_EQUAL;
            s_cmd.ch    = CH_EQ;
            mode_nxt    = MD_IDLE;
            len_nxt     = '0;
          end else begin
            use_f   = 1'b1;
            do_idle = 1'b1;
          end
        end
        MD_SLASH: begin
          if (c == CH_SLASH) begin
            mode_nxt = MD_COMMENT;
            len_nxt  = '0;
          end else begin
            use_f   = 1'b1;
            do_idle = 1'b1;
          end
        end
        MD_COMMENT: begin
          if (c == CH_NL) begin
            mode_nxt = MD_IDLE;
          end
        end
        default: begin
          do_idle = 1'b1;
        end
      endcase
    end

    if (do_idle) begin
      mode_nxt = i_mode;
      use_s    = i_sv;
      len_nxt  = i_start ? IDX_W'(1) : '0;
      if (i_start) begin
        kw_nxt = (c == CH_I) ? KW_I : KW_NONE;
      end
    end

    ext_store = ext && (len_r < IDX_W'(TEXT_CAP));
    if (ext_store) begin
      len_nxt = len_r + IDX_W'(1);
      case (kw_r)
        KW_I: begin
          if (c == CH_N) begin
            kw_nxt = KW_IN;
          end else if (c == CH_F) begin
            kw_nxt = KW_IF;
          end else begin
            kw_nxt = KW_NONE;
          end
        end
        KW_IN:   kw_nxt = (c == CH_T) ? KW_INT : KW_NONE;
        default: kw_nxt = KW_NONE;
      endcase
    end
  end

  // a flushed word moves the scanner to the other text bank
  assign wbank    = (use_f && f_cmd.kind == CK_TEXT) ? !bank_r : bank_r;
  assign bank_nxt = wbank;

  always_comb begin
    cmd.v0            = accept && (use_f || use_s);
    cmd.v1            = accept && use_f && use_s;
    cmd.c0            = use_f ? f_cmd : s_cmd;
    cmd.c0.last_in    = use_f ? !use_s : 1'b1;
    cmd.c1            = s_cmd;
    cmd.c1.last_in    = 1'b1;
  end

  always_comb begin
    wr.en   = accept && (ext_store || (do_idle && i_start));
    wr.addr = ext_store ? {bank_r, len_r} : {wbank, IDX_W'(0)};
    wr.data = c;
  end

  always_comb begin
    busy_nxt = busy_r;
    if (rel.en) begin
      busy_nxt[rel.bank] = 1'b0;
    end
    if (accept && use_f && f_cmd.kind == CK_TEXT) begin
      busy_nxt[bank_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MD_IDLE;
      kw_r   <= KW_NONE;
      len_r  <= '0;
      bank_r <= 1'b0;
      busy_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      if (accept) begin
        mode_r <= mode_nxt;
        kw_r   <= kw_nxt;
        len_r  <= len_nxt;
        bank_r <= bank_nxt;
      end
    end
  end

endmodule

>>> sv/slt_cmd_queue.sv
// short command queue between scanner and emitter, two pushes and one pop a cycle
module slt_cmd_queue import slt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_pair_t push,
  input  logic      pop,
  output cmd_t      head,
  output q_stat_t   stat
);

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = PW + 1;

  cmd_t          q_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  assign head       = q_r[rp_r];
  assign stat.empty = (cnt_r == '0);
  assign stat.room2 = (cnt_r <= CW'(DEPTH - 2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + PW'(push.v0) + PW'(push.v1);
      rp_r  <= rp_r + PW'(pop);
      cnt_r <= cnt_r + CW'(push.v0) + CW'(push.v1) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.v0) begin
      q_r[wp_r] <= push.c0;
    end
    if (push.v1) begin
      q_r[wp_r + PW'(1)] <= push.c1;
    end
  end

endmodule

>>> sv/slt_back.sv
// emitter: replays each token command one character a cycle into the result queue while it has room
module slt_back import slt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              head,
  input  q_stat_t           q_stat,
  output logic              pop,
  output rel_t              rel,
  output logic              rd_en,
  output logic [ADDR_W-1:0] rd_addr,
  input  logic [7:0]        rd_data,
  output logic              out_empty,
  input  logic              out_pop,
  output out_word_t         out_word
);

  localparam int OQ_DEPTH = 4;
  localparam int OPW      = $clog2(OQ_DEPTH);
  localparam int OCW      = OPW + 1;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t           state_r, state_nxt;
  cmd_t             cur_r;
  logic [IDX_W-1:0] idx_r;
  logic             s1_v_r;
  out_word_t        s1_r;
  logic             s1_mem_r;

  out_word_t      oq_r [OQ_DEPTH];
  logic [OPW-1:0] owp_r, orp_r;
  logic [OCW-1:0] ocnt_r;

  logic             room;
  logic             issue;
  logic             is_last;
  logic [IDX_W-1:0] last_idx;
  out_word_t        iss_word;
  out_word_t        push_word;
  logic             out_take;

  assign room    = (ocnt_r + OCW'(s1_v_r)) < OCW'(OQ_DEPTH);
  assign issue   = (state_r == ST_RUN) && room;
  assign pop     = (state_r == ST_IDLE) && !q_stat.empty;

  always_comb begin
    case (cur_r.kind)
      CK_TEXT: last_idx = cur_r.len - IDX_W'(1);
      CK_EQ2:  last_idx = IDX_W'(1);
      default: last_idx = '0;
    endcase
  end

  assign is_last  = (idx_r == last_idx);
  assign rd_en    = issue && (cur_r.kind == CK_TEXT);
  assign rd_addr  = {cur_r.bank, idx_r};
  assign rel.en   = issue && is_last && (cur_r.kind == CK_TEXT);
  assign rel.bank = cur_r.bank;

  always_comb begin
    iss_word.token_type    = cur_r.ttype;
    iss_word.text_char     = cur_r.ch;
    iss_word.char_index    = idx_r;
    iss_word.last_of_token = is_last;
    iss_word.last_of_input = is_last && cur_r.last_in;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (pop) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (issue && is_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      s1_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      s1_v_r  <= issue;
      if (pop) begin
        cur_r <= head;
        idx_r <= '0;
      end else if (issue) begin
        idx_r <= idx_r + IDX_W'(1);
      end
      if (issue) begin
        s1_r     <= iss_word;
        s1_mem_r <= (cur_r.kind == CK_TEXT);
      end
    end
  end

  // text characters arrive from memory in the cycle after the issue
  always_comb begin
    push_word = s1_r;
    if (s1_mem_r) begin
      push_word.text_char = rd_data;
    end
  end

  assign out_empty = (ocnt_r == '0);
  assign out_word  = oq_r[orp_r];
  assign out_take  = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= '0;
      orp_r  <= '0;
      ocnt_r <= '0;
    end else begin
      owp_r  <= owp_r + OPW'(s1_v_r);
      orp_r  <= orp_r + OPW'(out_take);
      ocnt_r <= ocnt_r + OCW'(s1_v_r) - OCW'(out_take);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      oq_r[owp_r] <= push_word;
    end
  end

endmodule

>>> sv/small_language_tokenizer.sv
// top level of the byte-stream tokenizer for a small c-like language
// a byte's command passes the command queue, the emitter and the result queue
// throughput: one byte a cycle while the command queue has room and the text banks
//   are free; the emitter replays one character a cycle while the result queue has room
// reset: synchronous, clears scanner, queues and bank flags; text memory is not cleared
`include "small_language_tokenizer_assert.svh"
module small_language_tokenizer import slt_pkg::*; #(
  parameter int MAX_TEXT = 31
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_word_t  in_word,
  input  logic      out_pop,
  output logic      out_empty,
  output out_word_t out_word
);

  cmd_pair_t         cmd;
  mem_wr_t           wr;
  q_stat_t           q_stat;
  rel_t              rel;
  cmd_t              head;
  logic              pop;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic              eof_head;
  logic              eof_ends;

  slt_front #(
    .MAX_TEXT (MAX_TEXT)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_word (in_word),
    .q_stat  (q_stat),
    .rel     (rel),
    .cmd     (cmd),
    .wr      (wr)
  );

  slt_cmd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd),
    .pop   (pop),
    .head  (head),
    .stat  (q_stat)
  );

  slt_text_mem u_mem (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  slt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .rel       (rel),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word)
  );

  assign eof_head = !out_empty && out_word.token_type == TT_EOF;
  assign eof_ends = out_word.last_of_token && out_word.last_of_input;

  `SLT_ASSERT_IMP(a_no_rw_clash, wr.en && rd_en, wr.addr != rd_addr, "write hits replayed word")
  `SLT_ASSERT_IMP(a_pair_room, cmd.v0, q_stat.room2, "command pushed without queue room")
  `SLT_ASSERT_IMP(a_eof_flags, eof_head, eof_ends, "eof word without end flags")
  `SLT_ASSERT_NXT(a_rel_single, rel.en, !rel.en, "bank released twice in a row")

endmodule

>>> bench/small_language_tokenizer_tb.sv
// self-checking testbench for the small-language tokenizer: directed rows, then random source text
`timescale 1ns / 1ps

module small_language_tokenizer_tb;
  import slt_pkg::*;

  localparam int MAX_TEXT       = 31;
  localparam int TEXT_CAP       = (MAX_TEXT < STORE_DEPTH) ? MAX_TEXT : STORE_DEPTH;
  localparam int RAND_PER_PHASE = 80;
  localparam int HOLD_LEN       = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 20;

  typedef enum logic [2:0] {
    LX_IDLE,
    LX_WORD,
    LX_DIGITS,
    LX_EQ,
    LX_SLASH,
    LX_COMMENT
  } lex_mode_t;

  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t res;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_push = 1'b0;
  logic      in_full;
  in_word_t  in_word = '0;
  logic      out_pop = 1'b0;
  logic      out_empty;
  out_word_t out_word;

  lex_mode_t  lex_mode = LX_IDLE;
  logic [7:0] text_buf [STORE_DEPTH];
  int         text_len = 0;

  out_word_t expected_chars[$];
  out_word_t want;
  dir_row_t  dir_rows[26];

  int errors = 0;
  int words_in = 0;
  int chars_out = 0;
  int eof_seen = 0;
  int longest = 0;
  int quiet = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;

  small_language_tokenizer #(.MAX_TEXT(MAX_TEXT)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_word  (in_word),
    .out_pop  (out_pop),
    .out_empty(out_empty),
    .out_word (out_word)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic void put_tok(ref out_word_t toks[$], input tok_type_t t,
                                  input logic [7:0] ch, input int idx, input logic last);
    out_word_t r;
    r.token_type    = t;
    r.text_char     = ch;
    r.char_index    = IDX_W'(idx);
    r.last_of_token = last;
    r.last_of_input = 1'b0;
    toks.push_back(r);
  endfunction

  function automatic void keep_char(logic [7:0] c);
    if (text_len < TEXT_CAP) begin
      text_buf[text_len] = c;
      text_len++;
    end
  endfunction

  function automatic void flush_pending(ref out_word_t toks[$]);
    tok_type_t t;
    if (lex_mode == LX_WORD || lex_mode == LX_DIGITS) begin
      t = TT_NUMBER;
      if (lex_mode == LX_WORD) begin
        if (text_len == 3 && text_buf[0] == "i" && text_buf[1] == "n" && text_buf[2] == "t")
          t = TT_INT;
        else if (text_len == 2 && text_buf[0] == "i" && text_buf[1] == "f")
          t = TT_IF;
        else
          t = TT_IDENT;
      end
      for (int i = 0; i < text_len; i++)
        put_tok(toks, t, text_buf[i], i, i == text_len - 1);
    end else if (lex_mode == LX_EQ) begin
      put_tok(toks, TT_ASSIGN, "=", 0, 1'b1);
    end else if (lex_mode == LX_SLASH) begin
      put_tok(toks, TT_UNKNOWN, "/", 0, 1'b1);
    end
  endfunction

  function automatic void start_token(logic [7:0] c, ref out_word_t toks[$]);
    lex_mode = LX_IDLE;
    text_len = 0;
    if (is_blank(c)) begin
      return;
    end else if (is_letter(c)) begin
      lex_mode = LX_WORD;
      keep_char(c);
    end else if (is_digit(c)) begin
      lex_mode = LX_DIGITS;
      keep_char(c);
    end else begin
      case (c)
        "=": lex_mode = LX_EQ;
        "/": lex_mode = LX_SLASH;
        "+": put_tok(toks, TT_PLUS, c, 0, 1'b1);
        "-": put_tok(toks, TT_MINUS, c, 0, 1'b1);
        "{": put_tok(toks, TT_LBRACE, c, 0, 1'b1);
        "}": put_tok(toks, TT_RBRACE, c, 0, 1'b1);
        "(": put_tok(toks, TT_LPAREN, c, 0, 1'b1);
        ")": put_tok(toks, TT_RPAREN, c, 0, 1'b1);
        ";": put_tok(toks, TT_SEMI, c, 0, 1'b1);
        default: put_tok(toks, TT_UNKNOWN, c, 0, 1'b1);
      endcase
    end
  endfunction

  function automatic void scan_word(in_word_t w, ref out_word_t toks[$]);
    int         first;
    logic [7:0] c;
    first = toks.size();
    c = w.data_byte;
    if (w.end_of_input) begin
      flush_pending(toks);
      put_tok(toks, TT_EOF, 8'h00, 0, 1'b1);
      lex_mode = LX_IDLE;
      text_len = 0;
    end else begin
      case (lex_mode)
        LX_WORD: begin
          if (is_letter(c) || is_digit(c)) begin
            keep_char(c);
          end else begin
            flush_pending(toks);
            start_token(c, toks);
          end
        end
        LX_DIGITS: begin
          if (is_digit(c)) begin
            keep_char(c);
          end else begin
            flush_pending(toks);
            start_token(c, toks);
          end
        end
        LX_EQ: begin
          if (c == "=") begin
            put_tok(toks, TT_EQUAL, "=", 0, 1'b0);
            put_tok(toks, TT_EQUAL, "=", 1, 1'b1);
            lex_mode = LX_IDLE;
            text_len = 0;
          end else begin
            flush_pending(toks);
            start_token(c, toks);
          end
        end
        LX_SLASH: begin
          if (c == "/") begin
            lex_mode = LX_COMMENT;
            text_len = 0;
          end else begin
            flush_pending(toks);
            start_token(c, toks);
          end
        end
        LX_COMMENT: begin
          if (c == 8'h0A) lex_mode = LX_IDLE;
        end
        default: start_token(c, toks);
      endcase
    end
    if (toks.size() > first) toks[toks.size() - 1].last_of_input = 1'b1;
  endfunction

  function automatic dir_row_t plain_row(logic [7:0] c);
    dir_row_t r;
    r.w     = '{data_byte: c, end_of_input: 1'b0};
    r.typed = 1'b0;
    r.res   = '0;
    return r;
  endfunction

  function automatic dir_row_t sym_row(logic [7:0] c, tok_type_t t);
    dir_row_t r;
    r.w     = '{data_byte: c, end_of_input: 1'b0};
    r.typed = 1'b1;
    r.res   = '{token_type: t, text_char: c, char_index: '0, last_of_token: 1'b1,
                last_of_input: 1'b1};
    return r;
  endfunction

  function automatic void push_char(ref in_word_t q[$], input logic [7:0] c);
    q.push_back('{data_byte: c, end_of_input: 1'b0});
  endfunction

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(1) != 0) return 8'("a" + $urandom_range(25));
    return 8'("A" + $urandom_range(25));
  endfunction

  function automatic int wide_len();
    case ($urandom_range(3))
      0: return 30;
      1: return 31;
      2: return 32;
      default: return 45;
    endcase
  endfunction

  function automatic void add_lexeme(ref in_word_t q[$]);
    int         kind;
    int         n;
    logic [7:0] c;
    string      kw;
    kind = $urandom_range(99);
    if (kind < 20) begin
      n = ($urandom_range(99) < 6) ? wide_len() : $urandom_range(1, 6);
      for (int i = 0; i < n; i++)
        push_char(q, (i == 0 || $urandom_range(2) != 0) ? rand_letter()
                                                          : 8'("0" + $urandom_range(9)));
    end else if (kind < 28) begin
      case ($urandom_range(5))
        0: kw = "int";
        1: kw = "if";
        2: kw = "in";
        3: kw = "iff";
        4: kw = "intx";
        default: kw = "If";
      endcase
      for (int i = 0; i < kw.len(); i++) push_char(q, kw[i]);
    end else if (kind < 40) begin
      n = ($urandom_range(99) < 6) ? wide_len() : $urandom_range(1, 6);
      for (int i = 0; i < n; i++) push_char(q, 8'("0" + $urandom_range(9)));
    end else if (kind < 48) begin
      push_char(q, "=");
      push_char(q, "=");
    end else if (kind < 54) begin
      push_char(q, "=");
    end else if (kind < 59) begin
      push_char(q, "/");
    end else if (kind < 64) begin
      push_char(q, "/");
      push_char(q, "/");
      n = $urandom_range(0, 8);
      for (int i = 0; i < n; i++) begin
        c = 8'($urandom_range(255));
        push_char(q, (c == 8'h0A) ? 8'h23 : c);
      end
      if ($urandom_range(4) != 0) push_char(q, 8'h0A);
    end else if (kind < 80) begin
      case ($urandom_range(6))
        0: push_char(q, "+");
        1: push_char(q, "-");
        2: push_char(q, "{");
        3: push_char(q, "}");
        4: push_char(q, "(");
        5: push_char(q, ")");
        default: push_char(q, ";");
      endcase
    end else if (kind < 92) begin
      case ($urandom_range(5))
        0: push_char(q, " ");
        1: push_char(q, 8'h09);
        2: push_char(q, 8'h0A);
        3: push_char(q, 8'h0B);
        4: push_char(q, 8'h0C);
        default: push_char(q, 8'h0D);
      endcase
    end else if (kind < 98) begin
      push_char(q, 8'($urandom_range(255)));
    end else begin
      q.push_back('{data_byte: 8'($urandom_range(255)), end_of_input: 1'b1});
    end
    if ($urandom_range(1) != 0) push_char(q, " ");
  endfunction

  task automatic offer(in_word_t w, bit typed, out_word_t res);
    out_word_t toks[$];
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_full) @(posedge clk);
    scan_word(w, toks);
    if (typed) begin
      expected_chars.push_back(res);
    end else begin
      foreach (toks[i]) expected_chars.push_back(toks[i]);
    end
    words_in++;
  endtask

  // result side: check, stall, watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        chars_out++;
        if (out_word.token_type == TT_EOF) eof_seen++;
        if (int'(out_word.char_index) + 1 > longest) longest = int'(out_word.char_index) + 1;
        if (expected_chars.size() == 0) begin
          $error("result word with nothing expected: %h", out_word);
          errors++;
        end else begin
          want = expected_chars.pop_front();
          if (out_word.token_type !== want.token_type) begin
            $error("token_type: expected %0d, got %0d", want.token_type, out_word.token_type);
            errors++;
          end
          if (out_word.text_char !== want.text_char) begin
            $error("text_char: expected %h, got %h", want.text_char, out_word.text_char);
            errors++;
          end
          if (out_word.char_index !== want.char_index) begin
            $error("char_index: expected %0d, got %0d", want.char_index, out_word.char_index);
            errors++;
          end
          if (out_word.last_of_token !== want.last_of_token) begin
            $error("last_of_token: expected %b, got %b", want.last_of_token,
                   out_word.last_of_token);
            errors++;
          end
          if (out_word.last_of_input !== want.last_of_input) begin
            $error("last_of_input: expected %b, got %b", want.last_of_input,
                   out_word.last_of_input);
            errors++;
          end
        end
      end
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= recv_stall_pct);
      end
      if ((in_push && !in_full) || (out_pop && !out_empty)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    in_word_t src[$];
    int       sent;
    rst_n <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    dir_rows = '{
      '{w: '{data_byte: 8'hA5, end_of_input: 1'b1}, typed: 1'b1,
        res: '{token_type: TT_EOF, text_char: 8'h00, char_index: '0, last_of_token: 1'b1,
               last_of_input: 1'b1}},
      sym_row("+", TT_PLUS),
      sym_row("-", TT_MINUS),
      sym_row("{", TT_LBRACE),
      sym_row("}", TT_RBRACE),
      sym_row("(", TT_LPAREN),
      sym_row(")", TT_RPAREN),
      sym_row(";", TT_SEMI),
      sym_row(8'h00, TT_UNKNOWN),
      sym_row(8'hFF, TT_UNKNOWN),
      plain_row("i"), plain_row("n"), plain_row("t"), plain_row(" "),
      plain_row("i"), plain_row("f"), plain_row("("),
      plain_row("9"), plain_row("="), plain_row("="),
      plain_row("="), plain_row("/"), plain_row("/"), plain_row(8'h0A),
      plain_row("7"),
      '{w: '{data_byte: 8'h5A, end_of_input: 1'b1}, typed: 1'b0, res: '0}
    };

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        3: begin send_idle_pct = 9;  recv_stall_pct = 9;  end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          hold_reqs++;
        end
      endcase
      if (p == 0) begin
        foreach (dir_rows[i]) offer(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].res);
      end
      sent = 0;
      while (sent < RAND_PER_PHASE) begin
        src.delete();
        add_lexeme(src);
        foreach (src[i]) offer(src[i], 1'b0, '0);
        sent += src.size();
      end
    end
    in_push <= 1'b0;

    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d source words (%0d directed) and %0d token characters,",
             words_in, $size(dir_rows), chars_out);
    $display("  %0d end-of-input marks, longest token text %0d, idle and back-pressure phases",
             eof_seen, longest);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
